### rtl/mcpbm_pkg.sv
// Shared types and constants for the multicart program bank mapper.
// No dependencies; used by every module of the block by scoped names.
package mcpbm_pkg;

	localparam int unsigned AddrW     = 16;
	localparam int unsigned MappedW   = 20;
	localparam int unsigned BankW     = 6;
	localparam int unsigned CountW    = 7;
	localparam int unsigned CmdW      = 9;
	localparam int unsigned LatchW    = 3;
	localparam int unsigned WinOffW   = 14;
	localparam int unsigned PatOffW   = 13;
	localparam int unsigned PaddrW    = 3;
	localparam int unsigned PdataW    = 32;
	localparam int unsigned StepCntW  = 3;

	localparam logic [1:0] MODE_CPU_RD = 2'd0;
	localparam logic [1:0] MODE_CPU_WR = 2'd1;
	localparam logic [1:0] MODE_PPU_RD = 2'd2;
	localparam logic [1:0] MODE_PPU_WR = 2'd3;

	localparam logic REG_PRG_BANK_COUNT = 1'b0;
	localparam logic REG_CHR_IS_RAM     = 1'b1;

	localparam logic [CountW-1:0] PRG_COUNT_RST = 7'd8;
	localparam logic              CHR_RAM_RST   = 1'b1;

	localparam logic [LatchW-1:0] BANK_PAIR_MASK = 3'h6;
	localparam logic [LatchW-1:0] BANK_ODD       = 3'h1;
	localparam logic [LatchW-1:0] BANK_TOP       = 3'h7;

	localparam logic [StepCntW-1:0] MOD_STEPS = 3'd6;

	typedef struct packed {
		logic [1:0]       mode;
		logic [AddrW-1:0] address;
		logic [7:0]       write_data;
	} in_t;

	typedef struct packed {
		logic               hit;
		logic [MappedW-1:0] mapped_address;
		logic               mirror_horizontal;
	} out_t;

	typedef struct packed {
		logic              start;
		logic [BankW-1:0]  dividend;
		logic [CountW-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [BankW-1:0] remainder;
	} mod_rsp_t;

endpackage

### rtl/mcpbm_mod_unit.sv
// Shared restoring remainder unit: one quotient bit per cycle.
// Depends on mcpbm_pkg for widths and request/response structs.
module mcpbm_mod_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  mcpbm_pkg::mod_req_t req,
	output mcpbm_pkg::mod_rsp_t rsp
);

	logic [mcpbm_pkg::CountW-1:0]   rem_q;
	logic [mcpbm_pkg::BankW-1:0]    dvd_q;
	logic [mcpbm_pkg::CountW-1:0]   dvs_q;
	logic [mcpbm_pkg::StepCntW-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [mcpbm_pkg::CountW:0]     trial;
	logic [mcpbm_pkg::CountW:0]     diff;
	logic                           ge;

	assign trial = {rem_q, dvd_q[mcpbm_pkg::BankW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= mcpbm_pkg::MOD_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 3'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[mcpbm_pkg::CountW-1:0] : trial[mcpbm_pkg::CountW-1:0];
			dvd_q <= {dvd_q[mcpbm_pkg::BankW-2:0], 1'b0};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q[mcpbm_pkg::BankW-1:0];

endmodule

### rtl/multicart_prg_bank_mapper.sv
// Multicart program bank mapper top level: latches, bank sequencer, translation.
// Depends on mcpbm_pkg and mcpbm_mod_unit.
// Registered output, valid the cycle after acceptance; reads take one request per cycle
// while the output register drains and no recompute runs. A latch or bank count write
// recomputes both window banks on the shared remainder unit (6 steps each), again on a
// new count. Reset: latches and window banks clear, bank count 8, pattern memory RAM.
module multicart_prg_bank_mapper (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mcpbm_pkg::in_t                     in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output mcpbm_pkg::out_t                    out_data,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mcpbm_pkg::PaddrW-1:0]       paddr,
	input  logic [mcpbm_pkg::PdataW-1:0]       pwdata,
	output logic [mcpbm_pkg::PdataW-1:0]       prdata,
	output logic                               pready
);

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_START_LO = 2'd1;
	localparam logic [1:0] ST_WAIT_LO  = 2'd2;
	localparam logic [1:0] ST_WAIT_HI  = 2'd3;

	logic [1:0]                      state_q;
	logic [mcpbm_pkg::CountW-1:0]    count_q;
	logic                            chr_ram_q;
	logic [mcpbm_pkg::CmdW-1:0]      cmd_q;
	logic [mcpbm_pkg::LatchW-1:0]    bank_q;
	logic [mcpbm_pkg::BankW-1:0]     low_q;
	logic [mcpbm_pkg::BankW-1:0]     high_q;
	logic                            out_valid_q;
	logic                            redo_q;
	mcpbm_pkg::out_t                 out_q;

	logic                            cfg_wr;
	logic                            cnt_wr;
	logic                            in_acc;
	logic                            cpu_wr_hi;
	logic                            cpu_wr_lo;
	logic                            recompute;
	logic [mcpbm_pkg::BankW-1:0]     base;
	logic [mcpbm_pkg::BankW-1:0]     lo_raw;
	logic [mcpbm_pkg::BankW-1:0]     hi_raw;
	logic [mcpbm_pkg::LatchW-1:0]    lo_sub;
	logic [mcpbm_pkg::LatchW-1:0]    hi_sub;
	mcpbm_pkg::mod_req_t             mod_req;
	mcpbm_pkg::mod_rsp_t             mod_rsp;
	mcpbm_pkg::out_t                 res;
	logic [mcpbm_pkg::AddrW-1:0]     a;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign cnt_wr   = cfg_wr && (paddr[2] == mcpbm_pkg::REG_PRG_BANK_COUNT);
	assign prdata   = (paddr[2] == mcpbm_pkg::REG_CHR_IS_RAM)
		? {{(mcpbm_pkg::PdataW-1){1'b0}}, chr_ram_q}
		: {{(mcpbm_pkg::PdataW-mcpbm_pkg::CountW){1'b0}}, count_q};

	assign in_ready  = (state_q == ST_IDLE) && !redo_q && (!out_valid_q || out_ready);
	assign in_acc    = in_valid & in_ready;
	assign a         = in_data.address;
	assign cpu_wr_hi = (in_data.mode == mcpbm_pkg::MODE_CPU_WR) && a[15] && a[14];
	assign cpu_wr_lo = (in_data.mode == mcpbm_pkg::MODE_CPU_WR) && a[15] && !a[14];
	assign recompute = (in_acc && (cpu_wr_hi || cpu_wr_lo)) || cnt_wr;

	// window bank candidates before the modulo
	always_comb begin
		base = cmd_q[7:2];
		if (!cmd_q[1]) begin
			lo_sub = bank_q;
			hi_sub = bank_q;
		end else if (cmd_q[8]) begin
			lo_sub = bank_q;
			hi_sub = mcpbm_pkg::BANK_TOP;
		end else begin
			lo_sub = bank_q & mcpbm_pkg::BANK_PAIR_MASK;
			hi_sub = (bank_q & mcpbm_pkg::BANK_PAIR_MASK) | mcpbm_pkg::BANK_ODD;
		end
		lo_raw = base | {3'b000, lo_sub};
		hi_raw = base | {3'b000, hi_sub};
	end

	always_comb begin
		mod_req.divisor  = count_q;
		mod_req.dividend = (state_q == ST_START_LO) ? lo_raw : hi_raw;
		mod_req.start    = ((state_q == ST_START_LO) && (count_q != '0))
			|| ((state_q == ST_WAIT_LO) && mod_rsp.done);
	end

	mcpbm_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// address translation of one request
	always_comb begin
		res.hit               = 1'b0;
		res.mapped_address    = '0;
		res.mirror_horizontal = cpu_wr_lo ? a[0] : cmd_q[0];
		unique case (in_data.mode)
			mcpbm_pkg::MODE_CPU_RD: begin
				if (a[15]) begin
					res.hit            = 1'b1;
					res.mapped_address = {(a[14] ? high_q : low_q), a[mcpbm_pkg::WinOffW-1:0]};
				end
			end
			mcpbm_pkg::MODE_PPU_RD: begin
				if (a[15:13] == 3'b000) begin
					res.hit            = 1'b1;
					res.mapped_address = {7'd0, a[mcpbm_pkg::PatOffW-1:0]};
				end
			end
			mcpbm_pkg::MODE_PPU_WR: begin
				if (a[15:13] == 3'b000 && chr_ram_q) begin
					res.hit            = 1'b1;
					res.mapped_address = {7'd0, a[mcpbm_pkg::PatOffW-1:0]};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= mcpbm_pkg::PRG_COUNT_RST;
			chr_ram_q   <= mcpbm_pkg::CHR_RAM_RST;
			cmd_q       <= '0;
			bank_q      <= '0;
			low_q       <= '0;
			high_q      <= '0;
			out_valid_q <= 1'b0;
			redo_q      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == mcpbm_pkg::REG_PRG_BANK_COUNT) begin
					count_q <= pwdata[mcpbm_pkg::CountW-1:0];
				end else begin
					chr_ram_q <= pwdata[0];
				end
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
				if (cpu_wr_hi) begin
					bank_q <= a[mcpbm_pkg::LatchW-1:0];
				end
				if (cpu_wr_lo) begin
					cmd_q <= a[mcpbm_pkg::CmdW-1:0];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// count changed mid-recompute: run it again before taking requests
			if (state_q != ST_IDLE && cnt_wr) begin
				redo_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (recompute || redo_q) begin
						state_q <= ST_START_LO;
						redo_q  <= 1'b0;
					end
				end
				ST_START_LO: begin
					if (count_q == '0) begin
						low_q   <= '0;
						high_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT_LO;
					end
				end
				ST_WAIT_LO: begin
					if (mod_rsp.done) begin
						low_q   <= mod_rsp.remainder;
						state_q <= ST_WAIT_HI;
					end
				end
				ST_WAIT_HI: begin
					if (mod_rsp.done) begin
						high_q  <= mod_rsp.remainder;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
